@@ sv/pcrel_pkg.sv @@
// shared types and constants for the pc-relative instruction relocator
`default_nettype none
package pcrel_pkg;

  // instruction class found by the decoder
  typedef enum logic [2:0] {
    K_NONE = 3'd0,
    K_ADRP = 3'd1,
    K_ADR  = 3'd2,
    K_BR   = 3'd3,
    K_LDR  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PASS  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  localparam logic [31:0] ADR_MASK  = 32'h9f00_0000;
  localparam logic [31:0] ADRP_OPC  = 32'h9000_0000;
  localparam logic [31:0] ADR_OPC   = 32'h1000_0000;
  localparam logic [31:0] BR_MASK   = 32'h7c00_0000;
  localparam logic [31:0] BR_OPC    = 32'h1400_0000;
  localparam logic [31:0] LDR_MASK  = 32'hff00_0000;
  localparam logic [31:0] LDR_OPC_W = 32'h1800_0000;
  localparam logic [31:0] LDR_OPC_X = 32'h5800_0000;
  localparam logic [31:0] ADR_KEEP  = 32'h9f00_001f;
  localparam logic [31:0] LDR_KEEP  = 32'hff00_001f;

  // decoded item: class plus the two addends of the absolute target
  typedef struct packed {
    kind_t       kind;
    logic [63:0] base;
    logic [63:0] offs;
  } dec_t;

endpackage
`default_nettype wire

@@ sv/pc_relative_insn_relocator_core.sv @@
// top level: four-stage pc-relative instruction relocation pipeline
//
//   channel | ports                                   | direction
//   in      | in_valid in_ready in_insn_word          | item in
//           | in_old_pc in_new_pc                     |
//   out     | out_valid out_ready out_word out_status | result out
//
// one item per cycle sustained while out_ready is high; out_valid is the last stage's valid bit
// stages: decode, target add, offset subtract, range check and re-encode
// each stage holds its item while the one after it is full and stalled
// reset clears only the stage valid bits
`default_nettype none
module pc_relative_insn_relocator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_insn_word,
  input  wire logic [63:0] in_old_pc,
  input  wire logic [63:0] in_new_pc,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_word,
  output logic [1:0]       out_status
);

  pcrel_pkg::dec_t    dec;

  logic               s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic               rdy1, rdy2, rdy3, rdy4;

  pcrel_pkg::dec_t    s1_dec_r;
  logic [31:0]        s1_op_r;
  logic [63:0]        s1_npc_r;

  pcrel_pkg::kind_t   s2_kind_r;
  logic [31:0]        s2_op_r;
  logic [63:0]        s2_tgt_r;
  logic [63:0]        s2_npc_r;

  pcrel_pkg::kind_t   s3_kind_r;
  logic [31:0]        s3_op_r;
  logic [63:0]        s3_d_r;

  logic [31:0]        s4_word_r, s4_word_nxt;
  pcrel_pkg::status_t s4_st_r, s4_st_nxt;

  logic [63:0]        sub_a, sub_b;
  logic               fits21, fits28;

  pcrel_dec u_dec (
    .insn_word (in_insn_word),
    .old_pc    (in_old_pc),
    .dec       (dec)
  );

  assign rdy4     = !s4_v_r || out_ready;
  assign rdy3     = !s3_v_r || rdy4;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_ready = rdy1;

  // adrp compares page numbers, the rest compare byte addresses
  always_comb begin
    if (s2_kind_r == pcrel_pkg::K_ADRP) begin
      sub_a = {12'd0, s2_tgt_r[63:12]};
      sub_b = {12'd0, s2_npc_r[63:12]};
    end else begin
      sub_a = s2_tgt_r;
      sub_b = s2_npc_r;
    end
  end

  assign fits21 = (&s3_d_r[63:20]) || !(|s3_d_r[63:20]);
  assign fits28 = (&s3_d_r[63:27]) || !(|s3_d_r[63:27]);

  always_comb begin
    s4_word_nxt = s3_op_r;
    s4_st_nxt   = pcrel_pkg::ST_PASS;
    case (s3_kind_r)
      pcrel_pkg::K_ADRP, pcrel_pkg::K_ADR: begin
        if (fits21) begin
          s4_word_nxt = (s3_op_r & pcrel_pkg::ADR_KEEP) |
                        {1'b0, s3_d_r[1:0], 5'd0, s3_d_r[20:2], 5'd0};
          s4_st_nxt   = pcrel_pkg::ST_OK;
        end else begin
          s4_st_nxt   = pcrel_pkg::ST_RANGE;
        end
      end
      pcrel_pkg::K_BR: begin
        if (s3_d_r[1:0] == 2'd0 && fits28) begin
          s4_word_nxt = {s3_op_r[31:26], s3_d_r[27:2]};
          s4_st_nxt   = pcrel_pkg::ST_OK;
        end else begin
          s4_st_nxt   = pcrel_pkg::ST_RANGE;
        end
      end
      pcrel_pkg::K_LDR: begin
        // low misaligned bits are dropped, not flagged
        if (fits21) begin
          s4_word_nxt = (s3_op_r & pcrel_pkg::LDR_KEEP) | {8'd0, s3_d_r[20:2], 5'd0};
          s4_st_nxt   = pcrel_pkg::ST_OK;
        end else begin
          s4_st_nxt   = pcrel_pkg::ST_RANGE;
        end
      end
      default: begin
        s4_word_nxt = s3_op_r;
        s4_st_nxt   = pcrel_pkg::ST_PASS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_dec_r <= dec;
      s1_op_r  <= in_insn_word;
      s1_npc_r <= in_new_pc;
    end
    if (rdy2) begin
      s2_kind_r <= s1_dec_r.kind;
      s2_op_r   <= s1_op_r;
      s2_tgt_r  <= s1_dec_r.base + s1_dec_r.offs;
      s2_npc_r  <= s1_npc_r;
    end
    if (rdy3) begin
      s3_kind_r <= s2_kind_r;
      s3_op_r   <= s2_op_r;
      s3_d_r    <= sub_a - sub_b;
    end
    if (rdy4) begin
      s4_word_r <= s4_word_nxt;
      s4_st_r   <= s4_st_nxt;
    end
  end

  assign out_valid  = s4_v_r;
  assign out_word   = s4_word_r;
  assign out_status = s4_st_r;

  a_no_code3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("status code three on output");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_v_r)
    else $error("accepted item lost at decode stage");

  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !rdy3 |=> s3_v_r && $stable(s3_d_r) && $stable(s3_op_r))
    else $error("stalled offset stage changed");

endmodule
`default_nettype wire

@@ sv/pcrel_dec.sv @@
// instruction class decode and immediate sign extension
`default_nettype none
module pcrel_dec (
  input  wire logic [31:0]     insn_word,
  input  wire logic [63:0]     old_pc,
  output pcrel_pkg::dec_t      dec
);

  logic [20:0] adr_imm;

  // adr/adrp immediate: immhi in [23:5], immlo in [30:29]
  assign adr_imm = {insn_word[23:5], insn_word[30:29]};

  always_comb begin
    dec.kind = pcrel_pkg::K_NONE;
    dec.base = old_pc;
    dec.offs = 64'd0;
    if ((insn_word & pcrel_pkg::ADR_MASK) == pcrel_pkg::ADRP_OPC) begin
      dec.kind = pcrel_pkg::K_ADRP;
      dec.base = {old_pc[63:12], 12'd0};
      dec.offs = {{31{adr_imm[20]}}, adr_imm, 12'd0};
    end else if ((insn_word & pcrel_pkg::ADR_MASK) == pcrel_pkg::ADR_OPC) begin
      dec.kind = pcrel_pkg::K_ADR;
      dec.offs = {{43{adr_imm[20]}}, adr_imm};
    end else if ((insn_word & pcrel_pkg::BR_MASK) == pcrel_pkg::BR_OPC) begin
      dec.kind = pcrel_pkg::K_BR;
      dec.offs = {{36{insn_word[25]}}, insn_word[25:0], 2'd0};
    end else if ((insn_word & pcrel_pkg::LDR_MASK) == pcrel_pkg::LDR_OPC_W ||
                 (insn_word & pcrel_pkg::LDR_MASK) == pcrel_pkg::LDR_OPC_X) begin
      dec.kind = pcrel_pkg::K_LDR;
      dec.offs = {{43{insn_word[23]}}, insn_word[23:5], 2'd0};
    end
  end

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// self-checking testbench for the pc-relative instruction relocator core
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 450;

  typedef struct packed {
    logic [31:0] word;
    logic [63:0] old_pc;
    logic [63:0] new_pc;
  } insn_item_t;

  typedef struct packed {
    logic [31:0]        word;
    pcrel_pkg::status_t status;
  } reloc_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_insn_word = '0;
  logic [63:0] in_old_pc = '0;
  logic [63:0] in_new_pc = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_word;
  logic [1:0]  out_status;

  insn_item_t pending_items[$];
  reloc_t     expected_relocs[$];
  insn_item_t next_item;
  bit         took = 1'b0;
  int         n_total = 0;
  int         n_accepted = 0;
  int         n_errors = 0;
  int         n_relocated = 0;
  int         n_passed = 0;
  int         n_range = 0;
  int         n_cycles = 0;
  int         burst_left = 8;
  int         gap_left = 0;
  int         rx_cycle = 0;
  int         hold_left = 0;

  pc_relative_insn_relocator_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_insn_word(in_insn_word),
    .in_old_pc   (in_old_pc),
    .in_new_pc   (in_new_pc),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .out_status  (out_status)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] sign_widen(logic [63:0] v, int bits);
    return $signed(v << (64 - bits)) >>> (64 - bits);
  endfunction

  // true when the signed value needs at most 'bits' bits
  function automatic bit fits_signed(logic [63:0] d, int bits);
    logic [63:0] hi;
    hi = $signed(d) >>> (bits - 1);
    return (hi == '0) || (hi == '1);
  endfunction

  function automatic reloc_t relocate(logic [31:0] w, logic [63:0] opc, logic [63:0] npc);
    reloc_t      r;
    logic [20:0] imm21;
    logic [63:0] imm;
    logic [63:0] target;
    logic [63:0] d;
    r.word = w;
    r.status = pcrel_pkg::ST_PASS;
    imm21 = {w[23:5], w[30:29]};
    if ((w & pcrel_pkg::ADR_MASK) == pcrel_pkg::ADRP_OPC) begin
      imm = {{43{imm21[20]}}, imm21};
      target = {opc[63:12], 12'h000} + (imm << 12);
      d = (target >> 12) - (npc >> 12);
      if (fits_signed(d, 21)) begin
        r.word = (w & pcrel_pkg::ADR_KEEP) | {1'b0, d[1:0], 5'b0, d[20:2], 5'b0};
        r.status = pcrel_pkg::ST_OK;
      end else begin
        r.status = pcrel_pkg::ST_RANGE;
      end
    end else if ((w & pcrel_pkg::ADR_MASK) == pcrel_pkg::ADR_OPC) begin
      imm = {{43{imm21[20]}}, imm21};
      d = opc + imm - npc;
      if (fits_signed(d, 21)) begin
        r.word = (w & pcrel_pkg::ADR_KEEP) | {1'b0, d[1:0], 5'b0, d[20:2], 5'b0};
        r.status = pcrel_pkg::ST_OK;
      end else begin
        r.status = pcrel_pkg::ST_RANGE;
      end
    end else if ((w & pcrel_pkg::BR_MASK) == pcrel_pkg::BR_OPC) begin
      imm = {{36{w[25]}}, w[25:0], 2'b00};
      d = opc + imm - npc;
      if (d[1:0] == 2'b00 && fits_signed(d, 28)) begin
        r.word = {w[31:26], d[27:2]};
        r.status = pcrel_pkg::ST_OK;
      end else begin
        r.status = pcrel_pkg::ST_RANGE;
      end
    end else if ((w & pcrel_pkg::LDR_MASK) == pcrel_pkg::LDR_OPC_W ||
                 (w & pcrel_pkg::LDR_MASK) == pcrel_pkg::LDR_OPC_X) begin
      imm = {{43{w[23]}}, w[23:5], 2'b00};
      d = opc + imm - npc;
      // low misaligned bits are simply dropped by the shift
      if (fits_signed(d, 21)) begin
        r.word = (w & pcrel_pkg::LDR_KEEP) | {8'b0, d[20:2], 5'b0};
        r.status = pcrel_pkg::ST_OK;
      end else begin
        r.status = pcrel_pkg::ST_RANGE;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] enc_adr(bit page, logic [20:0] imm21, logic [4:0] rd);
    return {page, imm21[1:0], 5'b10000, imm21[20:2], rd};
  endfunction

  function automatic logic [31:0] enc_b(bit link, logic [25:0] imm26);
    return {link, 5'b00101, imm26};
  endfunction

  function automatic logic [31:0] enc_ldr(bit wide, logic [18:0] imm19, logic [4:0] rt);
    return {1'b0, wide, 6'b011000, imm19, rt};
  endfunction

  function automatic insn_item_t random_item();
    insn_item_t it;
    logic [31:0] w;
    logic [63:0] opc;
    logic [63:0] delta;
    int          lim;
    bit          branch;
    w = $urandom;
    lim = 21;
    branch = 1'b0;
    case ($urandom_range(0, 9))
      0, 1: begin
        w = (w & ~pcrel_pkg::ADR_MASK) | pcrel_pkg::ADRP_OPC;
        lim = 33;
      end
      2, 3: w = (w & ~pcrel_pkg::ADR_MASK) | pcrel_pkg::ADR_OPC;
      4, 5: begin
        w = (w & ~pcrel_pkg::BR_MASK) | pcrel_pkg::BR_OPC;
        lim = 28;
        branch = 1'b1;
      end
      6: w = (w & ~pcrel_pkg::LDR_MASK) | pcrel_pkg::LDR_OPC_W;
      7: w = (w & ~pcrel_pkg::LDR_MASK) | pcrel_pkg::LDR_OPC_X;
      default: ;  // noise: raw random word
    endcase
    case ($urandom_range(0, 7))
      0: opc = 64'($urandom_range(0, 4095));
      1: opc = ~64'($urandom_range(0, 4095));
      default: opc = rand64();
    endcase
    case ($urandom_range(0, 3))
      0: delta = sign_widen(rand64(), 12);
      1, 2: delta = sign_widen(rand64(), lim + 1);
      default: delta = rand64();
    endcase
    if (branch && $urandom_range(0, 1) == 1)
      delta[1:0] = 2'b00;
    it.word = w;
    it.old_pc = opc;
    it.new_pc = opc + delta;
    return it;
  endfunction

  task automatic add_item(logic [31:0] w, logic [63:0] opc, logic [63:0] npc);
    pending_items.push_back({w, opc, npc});
  endtask

  // stimulus, reset and end of run
  initial begin
    logic [63:0] a;
    a = 64'h0000_4000_1234_5678;
    // adr around both ends of its range, and across address wrap
    add_item(enc_adr(1'b0, 21'h0, 5'd1), a, a);
    add_item(enc_adr(1'b0, 21'h0, 5'd2), a, a - 64'h000F_FFFF);
    add_item(enc_adr(1'b0, 21'h0, 5'd3), a, a - 64'h0010_0000);
    add_item(enc_adr(1'b0, 21'h0, 5'd4), a, a + 64'h0010_0000);
    add_item(enc_adr(1'b0, 21'h0, 5'd5), a, a + 64'h0010_0001);
    add_item(enc_adr(1'b0, 21'h1, 5'd6), '1, '0);
    // adrp on page numbers
    add_item(enc_adr(1'b1, 21'h0F_FFFF, 5'd7), a, a);
    add_item(enc_adr(1'b1, 21'h10_0000, 5'd8), a, a);
    add_item(enc_adr(1'b1, 21'h0, 5'd9), a, a - (64'd1 << 32));
    add_item(enc_adr(1'b1, 21'h1, 5'd10), 64'hFFFF_FFFF_FFFF_F123, '0);
    // b and bl: extremes, misaligned and out of range
    add_item(enc_b(1'b0, 26'h1FF_FFFF), a, a);
    add_item(enc_b(1'b1, 26'h200_0000), a, a);
    add_item(enc_b(1'b0, 26'h0), a, a + 64'd1);
    add_item(enc_b(1'b0, 26'h1FF_FFFF), a, a - 64'd4);
    add_item(enc_b(1'b1, 26'h0), a, a + (64'd1 << 27));
    // ldr literal: rounding toward minus infinity and range limits
    add_item(enc_ldr(1'b0, 19'h0, 5'd1), a, a + 64'd2);
    add_item(enc_ldr(1'b1, 19'h3_FFFF, 5'd2), a, a + 64'd3);
    add_item(enc_ldr(1'b1, 19'h0, 5'd3), a, a - 64'h0010_0000);
    add_item(enc_ldr(1'b0, 19'h4_0000, 5'd31), a, a);
    add_item(enc_ldr(1'b0, 19'h7_FFFF, 5'd0), '0, '1);
    // words that are not pc-relative
    add_item(32'h0000_0000, '0, '1);
    add_item(32'hFFFF_FFFF, '1, '0);
    add_item(32'hD503_201F, a, a + 64'd4);
    repeat (RANDOM_ITEMS) pending_items.push_back(random_item());
    n_total = pending_items.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total) @(negedge clk);
    while (expected_relocs.size() > 0) @(negedge clk);
    repeat (12) @(negedge clk);

    $display("checked %0d relocations: %0d relocated, %0d passed through, %0d out of range",
             n_relocated + n_passed + n_range, n_relocated, n_passed, n_range);
    $display("%0d directed and %0d random items, %0d mismatches",
             n_total - RANDOM_ITEMS, RANDOM_ITEMS, n_errors);
    if (n_errors == 0 && expected_relocs.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_insn_word <= next_item.word;
          in_old_pc <= next_item.old_pc;
          in_new_pc <= next_item.new_pc;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: phases of full rate, random and sparse stalls, plus long hold-offs
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle == 300 || rx_cycle == 900)
      hold_left = 80;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_cycle[7:6])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= ($urandom_range(0, 1) == 1);
        2'd2: out_ready <= (rx_cycle[1:0] == 2'd0);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // input side: predict each accepted item
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_relocs.push_back(relocate(in_insn_word, in_old_pc, in_new_pc));
      n_accepted++;
      took <= 1'b1;
    end else begin
      took <= 1'b0;
    end
  end

  // output side: compare against the oldest prediction
  always @(posedge clk) begin
    reloc_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_relocs.size() == 0) begin
        $error("unexpected item: out_word %h out_status %0d", out_word, out_status);
        n_errors++;
      end else begin
        exp_r = expected_relocs.pop_front();
        if (out_word !== exp_r.word) begin
          $error("out_word mismatch: expected %h, got %h", exp_r.word, out_word);
          n_errors++;
        end
        if (out_status !== exp_r.status) begin
          $error("out_status mismatch: expected %0d, got %0d", exp_r.status, out_status);
          n_errors++;
        end
        case (exp_r.status)
          pcrel_pkg::ST_OK: n_relocated++;
          pcrel_pkg::ST_PASS: n_passed++;
          default: n_range++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d items accepted",
               n_cycles, n_accepted, n_total);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
